@@ hw/rtl/ffa_pkg.sv @@
// Package for the first-fit region allocator: field widths, command, status
// and register codes, and the divider result word. Used by ffa_div and the allocator.
// No dependencies.
`default_nettype none
package ffa_pkg;

  localparam int CMD_W  = 2;
  localparam int SIZE_W = 27;
  localparam int OFF_W  = 26;
  localparam int STAT_W = 2;
  localparam int BB_W   = 17;
  localparam int BIU_W  = 11;
  localparam int DVD_W  = 28;

  localparam logic [CMD_W-1:0] CMD_CLAIM   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RSVD    = 2'd3;

  localparam logic [STAT_W-1:0] ST_CLAIMED = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_ROOM = 2'd1;
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD     = 2'd3;

  localparam logic REG_BLOCK_BYTES   = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;

  localparam logic [BB_W-1:0]  BB_RESET  = 17'd64;
  localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;
  localparam logic [33:0]      OFF_MAX   = 34'h3FFFFFF;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [BB_W-1:0]  rem;
  } div_res_t;

endpackage
`default_nettype wire

@@ hw/rtl/ffa_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on ffa_pkg.
`default_nettype none
module ffa_div (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [ffa_pkg::DVD_W-1:0] dividend,
  input  wire logic [ffa_pkg::BB_W-1:0]  divisor,
  output ffa_pkg::div_res_t           res
);
  import ffa_pkg::*;

  logic [DVD_W-1:0] q;
  logic [BB_W-1:0]  rem;
  logic [BB_W-1:0]  dvs;
  logic [4:0]       cnt;
  logic             busy;
  logic             done;
  logic [BB_W:0]    trial;

  assign trial = {rem, q[DVD_W-1]};

  // Control: counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one dividend bit and subtract where it fits.
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= BB_W'(trial - {1'b0, dvs});
        q   <= {q[DVD_W-2:0], 1'b1};
      end else begin
        rem <= trial[BB_W-1:0];
        q   <= {q[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign res.done = done;
  assign res.quot = q;
  assign res.rem  = rem;

endmodule
`default_nettype wire

@@ hw/rtl/ffa_map_ram.sv @@
// Occupancy map memory: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module ffa_map_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/bitmap_first_fit_region_allocator.sv @@
// First-fit contiguous block allocator over a one-bit-per-block map.
// Slave words carry a command in s_tuser and sizes in s_tdata; each word
// yields one master word with the status in m_tuser and the claimed byte
// offset in m_tdata. The map lives in a memory of MAP_WORD_BITS-bit words.
// Sizes are rounded with a serial divider (a release runs it twice). A
// claim then scans the map one block per cycle, pausing at each map word
// for a memory read, checks the offset product (S_MUL, S_MUL_CHK), and marks
// the run by read-modify-write passes (S_W_RD, S_W_MOD) over each word from
// word 0 to the run's last word. A release clears in the same way. Clear
// resets the per-word valid bits and goes straight to the result.
// s_tready is high only when no word is in work; a finished result waits in
// the output register while the next word is taken. A result that cannot
// leave because m_tready is low holds the block until it is taken.
// Reset sets block_bytes to 64 and blocks_in_use to 1024 and marks every
// map word free through per-word valid bits, so no clearing pass is needed.
// Configuration writes are taken at any edge with cfg_we high.
`default_nettype none
module bitmap_first_fit_region_allocator #(
  parameter int MAX_BLOCKS    = 1024,
  parameter int MAP_WORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata from bit 0: size_bytes[26:0], offset_bytes[25:0], zero pad.
  input  wire logic [55:0] s_tdata,
  // s_tuser: cmd[1:0].
  input  wire logic [ffa_pkg::CMD_W-1:0] s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata from bit 0: claimed_offset[25:0], zero pad.
  output logic      [31:0] m_tdata,
  // m_tuser: status[1:0].
  output logic      [ffa_pkg::STAT_W-1:0] m_tuser,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [ffa_pkg::BB_W-1:0] cfg_data
);
  import ffa_pkg::*;

  localparam int W     = MAP_WORD_BITS;
  localparam int WORDS = (MAX_BLOCKS + W - 1) / W;
  localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BI    = (W > 1) ? $clog2(W) : 1;
  localparam int PW    = $clog2(WORDS * W + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_CNT, S_WAIT_CNT, S_DIV_OFF, S_WAIT_OFF, S_SC_RD, S_SC_LD,
    S_SC_BIT, S_MUL, S_MUL_CHK, S_W_RD, S_W_MOD, S_RESULT
  } state_t;

  state_t            state;
  logic [BB_W-1:0]   block_bytes;
  logic [BIU_W-1:0]  blocks_in_use;
  logic [WORDS-1:0]  valid;
  logic [CMD_W-1:0]  cmd;
  logic [SIZE_W-1:0] size;
  logic [OFF_W-1:0]  offset;
  logic [DVD_W-1:0]  count;
  logic [PW-1:0]     nblk;
  logic [PW-1:0]     gi;
  logic [PW-1:0]     run;
  logic [WA-1:0]     widx;
  logic [BI-1:0]     bidx;
  logic [PW-1:0]     base;
  logic [PW-1:0]     lo;
  logic [PW-1:0]     hi;
  logic              op_set;
  logic [W-1:0]      wreg;
  logic [33:0]       prod;
  logic [STAT_W-1:0] res_status;
  logic [OFF_W-1:0]  res_off;
  div_res_t          div_res;
  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [W-1:0]      rdata;
  logic [W-1:0]      rword;
  logic [W-1:0]      mask;
  logic [W-1:0]      wdata;
  logic              ram_re;
  logic              ram_we;
  logic              bit_used;
  logic [DVD_W:0]    rel_end;

  // Effective block count, capped at the map size.
  assign nblk = (32'(blocks_in_use) > 32'(MAX_BLOCKS)) ? PW'(MAX_BLOCKS)
                                                       : PW'(blocks_in_use);

  // Divider operand: rounded-up size first, then the release offset.
  assign div_start = (state == S_DIV_CNT) || (state == S_DIV_OFF);
  assign div_dvd   = (state == S_DIV_CNT)
                   ? DVD_W'({1'b0, size} + {11'b0, block_bytes} - 28'd1)
                   : DVD_W'(offset);

  ffa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (block_bytes),
    .res      (div_res)
  );

  // Map memory access: reads in scan and update passes, writes on modify.
  assign ram_re = (state == S_SC_RD) || (state == S_W_RD);
  assign ram_we = (state == S_W_MOD);
  assign rword  = valid[widx] ? rdata : '0;

  // Word mask of the blocks in [lo, hi) for the current word.
  always_comb begin
    for (int b = 0; b < W; b++) begin
      mask[b] = ((base + PW'(b)) >= lo) && ((base + PW'(b)) < hi);
    end
  end
  assign wdata    = op_set ? (rword | mask) : (rword & ~mask);
  assign bit_used = wreg[bidx];
  assign rel_end  = {1'b0, div_res.quot} + {1'b0, count};

  ffa_map_ram #(.DEPTH(WORDS), .WIDTH(W), .AW(WA)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (widx),
    .rdata (rdata)
  );

  assign s_tready = (state == S_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes   <= BB_RESET;
      blocks_in_use <= BIU_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_BYTES:   block_bytes   <= cfg_data;
        REG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[BIU_W-1:0];
        default:           ;
      endcase
    end
  end

  // Sequencer and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // The result state reloads the output register itself.
      if (m_tvalid && m_tready && state != S_RESULT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd    <= s_tuser;
            size   <= s_tdata[SIZE_W-1:0];
            offset <= s_tdata[SIZE_W+OFF_W-1:SIZE_W];
            if (s_tuser == CMD_CLEAR) begin
              valid      <= '0;
              res_status <= ST_DONE;
              res_off    <= '0;
              state      <= S_RESULT;
            end else if (s_tuser != CMD_CLAIM && s_tuser != CMD_RELEASE ||
                         s_tdata[SIZE_W-1:0] == '0 || block_bytes == '0) begin
              res_status <= ST_BAD;
              res_off    <= '0;
              state      <= S_RESULT;
            end else begin
              state <= S_DIV_CNT;
            end
          end
        end
        S_DIV_CNT: state <= S_WAIT_CNT;
        S_WAIT_CNT: begin
          if (div_res.done) begin
            count   <= div_res.quot;
            res_off <= '0;
            if (cmd == CMD_RELEASE) begin
              state <= S_DIV_OFF;
            end else if (div_res.quot > DVD_W'(nblk)) begin
              res_status <= ST_NO_ROOM;
              state      <= S_RESULT;
            end else begin
              gi    <= '0;
              run   <= '0;
              widx  <= '0;
              bidx  <= '0;
              state <= S_SC_RD;
            end
          end
        end
        S_DIV_OFF: state <= S_WAIT_OFF;
        S_WAIT_OFF: begin
          if (div_res.done) begin
            if (div_res.rem != '0) begin
              res_status <= ST_BAD;
              state      <= S_RESULT;
            end else if (div_res.quot >= DVD_W'(nblk)) begin
              res_status <= ST_DONE;
              state      <= S_RESULT;
            end else begin
              lo     <= PW'(div_res.quot);
              hi     <= (rel_end > (DVD_W+1)'(nblk)) ? nblk : PW'(rel_end);
              op_set <= 1'b0;
              widx   <= '0;
              base   <= '0;
              state  <= S_W_RD;
            end
          end
        end
        S_SC_RD: state <= S_SC_LD;
        S_SC_LD: begin
          wreg  <= rword;
          state <= S_SC_BIT;
        end
        S_SC_BIT: begin
          if (gi >= nblk) begin
            res_status <= ST_NO_ROOM;
            state      <= S_RESULT;
          end else if (!bit_used && (DVD_W'(run) + 28'd1 >= count)) begin
            lo    <= PW'(DVD_W'(gi) + 28'd1 - count);
            hi    <= gi + PW'(1);
            state <= S_MUL;
          end else begin
            run <= bit_used ? '0 : run + PW'(1);
            gi  <= gi + PW'(1);
            if (32'(bidx) == W - 1) begin
              bidx  <= '0;
              widx  <= widx + WA'(1);
              state <= S_SC_RD;
            end else begin
              bidx <= bidx + BI'(1);
            end
          end
        end
        S_MUL: begin
          prod  <= 34'(lo) * 34'(block_bytes);
          state <= S_MUL_CHK;
        end
        S_MUL_CHK: begin
          if (prod > OFF_MAX) begin
            res_status <= ST_NO_ROOM;
            state      <= S_RESULT;
          end else begin
            res_off <= prod[OFF_W-1:0];
            op_set  <= 1'b1;
            widx    <= '0;
            base    <= '0;
            state   <= S_W_RD;
          end
        end
        S_W_RD: state <= S_W_MOD;
        S_W_MOD: begin
          valid[widx] <= 1'b1;
          if (32'(base) + W >= 32'(hi)) begin
            res_status <= op_set ? ST_CLAIMED : ST_DONE;
            state      <= S_RESULT;
          end else begin
            widx  <= widx + WA'(1);
            base  <= base + PW'(W);
            state <= S_W_RD;
          end
        end
        S_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {6'b0, res_off};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
